### hdl/bcu_pkg.sv
// Package for the barycentric coordinate unit.
// Holds the widths, types and pipeline depths shared by every file; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bcu_pkg;

    localparam int COORD_WIDTH      = 16;
    localparam int RESULT_FRAC_BITS = 16;
    localparam int WEIGHT_WIDTH     = 32;

    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
    localparam int CROSS_WIDTH = PROD_WIDTH + 1;
    localparam int MAG_WIDTH   = CROSS_WIDTH;
    localparam int QUOT_WIDTH  = MAG_WIDTH + RESULT_FRAC_BITS;
    localparam int REM_WIDTH   = MAG_WIDTH + 1;
    localparam int DIV_STAGES  = QUOT_WIDTH;
    localparam int PIPE_DEPTH  = DIV_STAGES + 5;

    typedef logic signed [COORD_WIDTH-1:0]  coord_t;
    typedef logic signed [DIFF_WIDTH-1:0]   diff_t;
    typedef logic signed [PROD_WIDTH-1:0]   prod_t;
    typedef logic signed [CROSS_WIDTH-1:0]  cross_t;
    typedef logic        [MAG_WIDTH-1:0]    mag_t;
    typedef logic        [QUOT_WIDTH-1:0]   quot_t;
    typedef logic signed [WEIGHT_WIDTH-1:0] weight_t;

    localparam weight_t WEIGHT_MAX = {1'b0, {(WEIGHT_WIDTH-1){1'b1}}};
    localparam weight_t WEIGHT_MIN = {1'b1, {(WEIGHT_WIDTH-1){1'b0}}};

endpackage

`default_nettype wire

### hdl/bcu_req_if.sv
// Input channel of the barycentric coordinate unit: point and three vertices.
// Depends on bcu_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bcu_req_if
    import bcu_pkg::*;
;
    logic   valid;
    logic   ready;
    coord_t point_x;
    coord_t point_y;
    coord_t vertex_a_x;
    coord_t vertex_a_y;
    coord_t vertex_b_x;
    coord_t vertex_b_y;
    coord_t vertex_c_x;
    coord_t vertex_c_y;

    modport source (output valid, point_x, point_y, vertex_a_x, vertex_a_y,
                    vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y, input ready);
    modport sink   (input valid, point_x, point_y, vertex_a_x, vertex_a_y,
                    vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y, output ready);
endinterface

`default_nettype wire

### hdl/bcu_rsp_if.sv
// Output channel of the barycentric coordinate unit: three weights and a flag.
// Depends on bcu_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bcu_rsp_if
    import bcu_pkg::*;
;
    logic    valid;
    logic    ready;
    weight_t weight_alpha;
    weight_t weight_beta;
    weight_t weight_gamma;
    logic    degenerate;

    modport source (output valid, weight_alpha, weight_beta, weight_gamma, degenerate,
                    input ready);
    modport sink   (input valid, weight_alpha, weight_beta, weight_gamma, degenerate,
                    output ready);
endinterface

`default_nettype wire

### hdl/bcu_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
// Unsigned magnitudes; sign travels alongside. Depends on bcu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bcu_divider
    import bcu_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  en,
    input  wire quot_t num,
    input  wire mag_t  den,
    input  wire logic  neg,
    output quot_t      quot,
    output logic       quot_neg
);

    mag_t  rem_reg  [DIV_STAGES];
    quot_t num_reg  [DIV_STAGES];
    mag_t  den_reg  [DIV_STAGES];
    quot_t quot_reg [DIV_STAGES];
    logic  neg_reg  [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        mag_t                 src_rem;
        quot_t                src_num;
        mag_t                 src_den;
        quot_t                src_quot;
        logic                 src_neg;
        logic [REM_WIDTH-1:0] trial;
        logic                 ge;
        mag_t                 rem_next;

        if (k == 0) begin : g_first
            assign src_rem  = '0;
            assign src_num  = num;
            assign src_den  = den;
            assign src_quot = '0;
            assign src_neg  = neg;
        end else begin : g_rest
            assign src_rem  = rem_reg[k-1];
            assign src_num  = num_reg[k-1];
            assign src_den  = den_reg[k-1];
            assign src_quot = quot_reg[k-1];
            assign src_neg  = neg_reg[k-1];
        end

        always_comb
        begin
            trial    = {src_rem, src_num[QUOT_WIDTH-1]};
            ge       = (trial >= {1'b0, src_den});
            rem_next = ge ? MAG_WIDTH'(trial - {1'b0, src_den}) : MAG_WIDTH'(trial);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                num_reg[k]  <= {src_num[QUOT_WIDTH-2:0], 1'b0};
                den_reg[k]  <= src_den;
                quot_reg[k] <= {src_quot[QUOT_WIDTH-2:0], ge};
                neg_reg[k]  <= src_neg;
            end
        end
    end

    assign quot     = quot_reg[DIV_STAGES-1];
    assign quot_neg = neg_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

### hdl/barycentric_coordinates_2d_unit.sv
// Top level of the barycentric coordinate unit.
// Depends on bcu_pkg, bcu_req_if, bcu_rsp_if and bcu_divider.
//
// Takes one transfer per cycle and returns one result per transfer, in order,
// through these steps: differences, eight 17x17 products, cross products,
// magnitudes, then one restoring-divider stage per quotient bit, then sign
// and saturation into the output register.
// The whole pipe advances when the output register is empty or being taken;
// a stalled output holds every stage. A zero determinant sets degenerate and
// gives zero weights.
`timescale 1ns / 1ps
`default_nettype none

module barycentric_coordinates_2d_unit
    import bcu_pkg::*;
(
    input wire logic  clk,
    input wire logic  rst_n,
    bcu_req_if.sink   req,
    bcu_rsp_if.source rsp
);

    logic en;
    logic valid_reg [PIPE_DEPTH];

    assign en        = !valid_reg[PIPE_DEPTH-1] || rsp.ready;
    assign req.ready = en;
    assign rsp.valid = valid_reg[PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_DEPTH; i++)
                valid_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= req.valid;
            for (int i = 1; i < PIPE_DEPTH; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    // stage 1: edge vectors
    diff_t bax_reg, bay_reg, cax_reg, cay_reg;
    diff_t apx_reg, apy_reg, bpx_reg, bpy_reg, cpx_reg, cpy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bax_reg <= DIFF_WIDTH'(req.vertex_b_x) - DIFF_WIDTH'(req.vertex_a_x);
            bay_reg <= DIFF_WIDTH'(req.vertex_b_y) - DIFF_WIDTH'(req.vertex_a_y);
            cax_reg <= DIFF_WIDTH'(req.vertex_c_x) - DIFF_WIDTH'(req.vertex_a_x);
            cay_reg <= DIFF_WIDTH'(req.vertex_c_y) - DIFF_WIDTH'(req.vertex_a_y);
            apx_reg <= DIFF_WIDTH'(req.vertex_a_x) - DIFF_WIDTH'(req.point_x);
            apy_reg <= DIFF_WIDTH'(req.vertex_a_y) - DIFF_WIDTH'(req.point_y);
            bpx_reg <= DIFF_WIDTH'(req.vertex_b_x) - DIFF_WIDTH'(req.point_x);
            bpy_reg <= DIFF_WIDTH'(req.vertex_b_y) - DIFF_WIDTH'(req.point_y);
            cpx_reg <= DIFF_WIDTH'(req.vertex_c_x) - DIFF_WIDTH'(req.point_x);
            cpy_reg <= DIFF_WIDTH'(req.vertex_c_y) - DIFF_WIDTH'(req.point_y);
        end
    end

    // stage 2: products
    prod_t dp_reg, dn_reg, ap_reg, an_reg, bp_reg, bn_reg, gp_reg, gn_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dp_reg <= bax_reg * cay_reg;
            dn_reg <= cax_reg * bay_reg;
            ap_reg <= bpx_reg * cpy_reg;
            an_reg <= cpx_reg * bpy_reg;
            bp_reg <= cpx_reg * apy_reg;
            bn_reg <= apx_reg * cpy_reg;
            gp_reg <= apx_reg * bpy_reg;
            gn_reg <= bpx_reg * apy_reg;
        end
    end

    // stage 3: cross products
    cross_t det_reg, alpha_reg, beta_reg, gamma_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg   <= CROSS_WIDTH'(dp_reg) - CROSS_WIDTH'(dn_reg);
            alpha_reg <= CROSS_WIDTH'(ap_reg) - CROSS_WIDTH'(an_reg);
            beta_reg  <= CROSS_WIDTH'(bp_reg) - CROSS_WIDTH'(bn_reg);
            gamma_reg <= CROSS_WIDTH'(gp_reg) - CROSS_WIDTH'(gn_reg);
        end
    end

    // stage 4: magnitudes and quotient signs
    mag_t den_mag_reg;
    mag_t num_mag_reg [3];
    logic neg_reg     [3];
    logic deg_reg;
    cross_t nums [3];

    assign nums[0] = alpha_reg;
    assign nums[1] = beta_reg;
    assign nums[2] = gamma_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_mag_reg <= det_reg[CROSS_WIDTH-1] ? mag_t'(-det_reg) : mag_t'(det_reg);
            deg_reg     <= (det_reg == '0);
            for (int j = 0; j < 3; j++)
            begin
                num_mag_reg[j] <= nums[j][CROSS_WIDTH-1] ? mag_t'(-nums[j])
                                                         : mag_t'(nums[j]);
                neg_reg[j]     <= nums[j][CROSS_WIDTH-1] ^ det_reg[CROSS_WIDTH-1];
            end
        end
    end

    // division lanes
    quot_t quot     [3];
    logic  quot_neg [3];

    for (genvar j = 0; j < 3; j++) begin : g_lane
        bcu_divider u_div (
            .clk      (clk),
            .en       (en),
            .num      ({num_mag_reg[j], {RESULT_FRAC_BITS{1'b0}}}),
            .den      (den_mag_reg),
            .neg      (neg_reg[j]),
            .quot     (quot[j]),
            .quot_neg (quot_neg[j])
        );
    end

    logic deg_pipe_reg [DIV_STAGES];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            deg_pipe_reg[0] <= deg_reg;
            for (int i = 1; i < DIV_STAGES; i++)
                deg_pipe_reg[i] <= deg_pipe_reg[i-1];
        end
    end

    // output stage: sign, saturation, degenerate zeroing
    weight_t weight_next [3];
    weight_t weight_reg  [3];
    logic    deg_out_reg;
    quot_t   neg_limit;
    quot_t   pos_limit;

    assign neg_limit = QUOT_WIDTH'({1'b0, WEIGHT_MIN});
    assign pos_limit = QUOT_WIDTH'({1'b0, WEIGHT_MAX});

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            if (deg_pipe_reg[DIV_STAGES-1])
                weight_next[j] = '0;
            else if (quot_neg[j])
                weight_next[j] = (quot[j] > neg_limit) ? WEIGHT_MIN
                                 : -weight_t'(quot[j][WEIGHT_WIDTH-1:0]);
            else
                weight_next[j] = (quot[j] > pos_limit) ? WEIGHT_MAX
                                 : weight_t'(quot[j][WEIGHT_WIDTH-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
                weight_reg[j] <= weight_next[j];
            deg_out_reg <= deg_pipe_reg[DIV_STAGES-1];
        end
    end

    assign rsp.weight_alpha = weight_reg[0];
    assign rsp.weight_beta  = weight_reg[1];
    assign rsp.weight_gamma = weight_reg[2];
    assign rsp.degenerate   = deg_out_reg;

endmodule

`default_nettype wire
